FILE: rtl/core/fsca_pkg.sv
// Shared types, constants and a helper function for the four-state cellular automaton row.
package fsca_pkg;

    localparam int MASK_W     = 32;
    localparam int NEW_ROW_W  = 64;
    localparam int RULE_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int RULE_TBL_W = 2 * RULE_W;

    typedef logic [1:0]            t_state;
    typedef logic [RULE_TBL_W-1:0] t_rule_table;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_MODE = 2'd2;

    localparam t_state ST_ZERO  = 2'd0;
    localparam t_state ST_ONE   = 2'd1;
    localparam t_state ST_TWO   = 2'd2;
    localparam t_state ST_THREE = 2'd3;

    // P1 takes priority over P2 when both are present at a cell.
    function automatic t_state f_morph(t_state s, logic p1, logic p2);
        t_state r;
        r = s;
        if (p1) begin
            if (s == ST_ZERO) begin
                r = ST_TWO;
            end else if (s == ST_ONE) begin
                r = ST_THREE;
            end
        end else if (p2) begin
            if (s == ST_ZERO) begin
                r = ST_ONE;
            end else if (s == ST_TWO) begin
                r = ST_THREE;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/fsca_cell.sv
// Rule table lookup for one cell from its modified neighborhood.
module fsca_cell
    import fsca_pkg::*;
(
    input  t_state      i_left,
    input  t_state      i_centre,
    input  t_state      i_right,
    input  t_rule_table i_rule,
    output t_state      o_state
);

    logic [5:0] w_index;

    assign w_index = {i_left, i_centre, i_right};
    assign o_state = i_rule[{w_index, 1'b0} +: 2];

endmodule

FILE: rtl/core/four_state_ca_row_step_with_morphogen.sv
// Top level of the four-state cellular automaton row stepper with morphogen inputs.
//
// Each input transfer carries a P1 mask, a P2 mask and a restart flag and advances the
// stored row by one time step. Each step produces exactly one output transfer on o_new_row,
// two bits per cell with cell 0 lowest; bits of cells at or above CELL_COUNT read as zero.
// The configuration channel writes the rule table low half (index 0), the rule table high
// half (index 1) and ring mode (index 2); other indexes are ignored. It is always ready.
// An accepted item sits in the input register, and the updated row moves into the result
// register when that is free or being taken. Throughput is one item per cycle while the
// receiver takes results, set by the single input register and result register.
// The stored row is updated when an item moves into the result register, so the next item
// sees it without a bubble. When the receiver stalls, the result register holds, one more
// item waits in the input register, and then o_in_ready drops until the result is taken.
// A synchronous active-low reset clears the row and the rule table, sets ring mode, and
// empties both registers.
module four_state_ca_row_step_with_morphogen
    import fsca_pkg::*;
#(
    parameter int CELL_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MASK_W-1:0]    i_p1_mask,
    input  logic [MASK_W-1:0]    i_p2_mask,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [NEW_ROW_W-1:0] o_new_row,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RULE_W-1:0]    i_cfg_data
);

    localparam int ROW_W = 2 * CELL_COUNT;

    logic [RULE_W-1:0]     r_rule_low;
    logic [RULE_W-1:0]     r_rule_high;
    logic                  r_ring;
    logic [ROW_W-1:0]      r_cell_row;
    logic                  r_in_valid;
    logic [CELL_COUNT-1:0] r_p1;
    logic [CELL_COUNT-1:0] r_p2;
    logic                  r_restart;
    logic                  r_out_valid;
    logic [ROW_W-1:0]      r_new_row;

    logic                  n_in_valid;
    logic                  n_out_valid;
    logic [ROW_W-1:0]      n_new_row;

    logic                  w_in_xfer;
    logic                  w_advance;
    logic [ROW_W-1:0]      w_old_row;
    t_state                w_mod [CELL_COUNT];
    t_rule_table           w_rule;

    assign o_cfg_ready = 1'b1;
    assign w_rule      = {r_rule_high, r_rule_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_low  <= '0;
            r_rule_high <= '0;
            r_ring      <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RULE_LOW:  r_rule_low  <= i_cfg_data;
                CFG_RULE_HIGH: r_rule_high <= i_cfg_data;
                CFG_RING_MODE: r_ring      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_xfer) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cell_row  <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_cell_row <= n_new_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_p1      <= i_p1_mask[CELL_COUNT-1:0];
            r_p2      <= i_p2_mask[CELL_COUNT-1:0];
            r_restart <= i_restart;
        end
        if (w_advance) begin
            r_new_row <= n_new_row;
        end
    end

    assign w_old_row = r_restart ? '0 : r_cell_row;

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_morph
        assign w_mod[g] = f_morph(w_old_row[2*g +: 2], r_p1[g], r_p2[g]);
    end

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        t_state w_left;
        t_state w_right;
        t_state w_state;

        if (g == 0) begin : g_lo
            assign w_left = r_ring ? w_mod[CELL_COUNT-1] : ST_ZERO;
        end else begin : g_lo
            assign w_left = w_mod[g-1];
        end

        if (g == CELL_COUNT - 1) begin : g_hi
            assign w_right = r_ring ? w_mod[0] : ST_ZERO;
        end else begin : g_hi
            assign w_right = w_mod[g+1];
        end

        fsca_cell u_cell (
            .i_left   (w_left),
            .i_centre (w_mod[g]),
            .i_right  (w_right),
            .i_rule   (w_rule),
            .o_state  (w_state)
        );

        assign n_new_row[2*g +: 2] = w_state;
    end

    assign o_out_valid = r_out_valid;
    assign o_new_row   = NEW_ROW_W'(r_new_row);

`ifndef SYNTHESIS
    localparam logic [NEW_ROW_W-1:0] ROW_MASK = {NEW_ROW_W{1'b1}} >> (NEW_ROW_W - ROW_W);

    a_unused_cells_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_new_row & ~ROW_MASK) == '0))
        else $error("Result carries bits above the last cell.");

    a_row_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_new_row == r_cell_row))
        else $error("Stored row differs from the offered result.");

    a_input_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_in_valid)
        else $error("Accepted item was not held in the input register.");

    a_stalled_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_p1) && $stable(r_restart)))
        else $error("Waiting item was lost while the result register was full.");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the four-state cellular automaton row stepper.
`timescale 1ns / 100ps

module tb;
    import fsca_pkg::*;

    localparam int CELLS          = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 65;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        KEEP_CENTRE,
        TAKE_LEFT,
        TAKE_RIGHT
    } t_neighbour;

    class ca_scoreboard;
        int unsigned          n_cells;
        logic [NEW_ROW_W-1:0] row_q;
        logic [RULE_W-1:0]    rule_lo;
        logic [RULE_W-1:0]    rule_hi;
        logic                 ring;
        logic [NEW_ROW_W-1:0] expected_rows[$];
        int                   errors;
        int                   checked;

        function new(int unsigned cells);
            n_cells = cells;
            row_q   = '0;
            rule_lo = '0;
            rule_hi = '0;
            ring    = 1'b1;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RULE_W-1:0] data);
            case (idx)
                CFG_RULE_LOW: begin
                    rule_lo = data;
                end
                CFG_RULE_HIGH: begin
                    rule_hi = data;
                end
                CFG_RING_MODE: begin
                    ring = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        // P1 sets the upper state bit and P2 the lower one, P1 taking priority.
        function t_state morph(t_state s, logic p1, logic p2);
            if (p1) begin
                return s | 2'b10;
            end
            if (p2) begin
                return s | 2'b01;
            end
            return s;
        endfunction

        function logic [NEW_ROW_W-1:0] advance_row(logic [MASK_W-1:0] p1,
                                                   logic [MASK_W-1:0] p2, logic rs);
            t_state               cur [MASK_W];
            logic [NEW_ROW_W-1:0] prev;
            logic [NEW_ROW_W-1:0] nxt;
            logic [RULE_TBL_W-1:0] tbl;
            t_state               lft;
            t_state               rgt;
            logic [5:0]           idx;
            prev = rs ? '0 : row_q;
            nxt  = '0;
            tbl  = {rule_hi, rule_lo};
            for (int c = 0; c < n_cells; c++) begin
                cur[c] = morph(prev[2*c +: 2], p1[c], p2[c]);
            end
            for (int c = 0; c < n_cells; c++) begin
                if (c == 0) begin
                    lft = ring ? cur[n_cells-1] : ST_ZERO;
                end else begin
                    lft = cur[c-1];
                end
                if (c == n_cells - 1) begin
                    rgt = ring ? cur[0] : ST_ZERO;
                end else begin
                    rgt = cur[c+1];
                end
                idx = {lft, cur[c], rgt};
                nxt[2*c +: 2] = tbl[2*int'(idx) +: 2];
            end
            row_q = nxt;
            return nxt;
        endfunction

        function void note_input(logic [MASK_W-1:0] p1, logic [MASK_W-1:0] p2, logic rs);
            expected_rows.push_back(advance_row(p1, p2, rs));
        endfunction

        function void check_row(logic [NEW_ROW_W-1:0] actual);
            logic [NEW_ROW_W-1:0] want;
            if (expected_rows.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Unexpected row transfer: actual %h", actual);
                end
                return;
            end
            want = expected_rows.pop_front();
            checked++;
            if (actual !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Row mismatch: expected %h actual %h", want, actual);
                end
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [MASK_W-1:0]    p1_mask   = '0;
    logic [MASK_W-1:0]    p2_mask   = '0;
    logic                 restart   = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [NEW_ROW_W-1:0] new_row;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RULE_W-1:0]    cfg_data  = '0;

    ca_scoreboard sb;
    bit           no_idle   = 1'b0;
    int           n_items   = 0;
    int           n_cfg     = 0;
    int           n_restart = 0;
    int           n_ringoff = 0;
    int           idle_cycles = 0;

    four_state_ca_row_step_with_morphogen #(
        .CELL_COUNT(CELLS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_p1_mask   (p1_mask),
        .i_p2_mask   (p2_mask),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_new_row   (new_row),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int stall;
        while (!rst_n) @(negedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_row(new_row);
            @(negedge clk);
        end
    end

    task automatic send_item(logic [MASK_W-1:0] m1, logic [MASK_W-1:0] m2, logic rs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        p1_mask  <= m1;
        p2_mask  <= m2;
        restart  <= rs;
        do @(posedge clk); while (!in_ready);
        sb.note_input(m1, m2, rs);
        n_items++;
        if (rs) begin
            n_restart++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_rows.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RULE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        n_cfg++;
        if (idx == CFG_RING_MODE && !data[0]) begin
            n_ringoff++;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_rules(logic [RULE_TBL_W-1:0] tbl, logic [RULE_W-1:0] ring_word);
        drain();
        cfg_write(CFG_RULE_LOW, tbl[RULE_W-1:0]);
        cfg_write(CFG_RULE_HIGH, tbl[RULE_TBL_W-1:RULE_W]);
        cfg_write(CFG_RING_MODE, ring_word);
    endtask

    function automatic t_rule_table neighbour_table(t_neighbour pick);
        t_rule_table tbl;
        logic [5:0]  idx;
        tbl = '0;
        for (int i = 0; i < 64; i++) begin
            idx = i[5:0];
            case (pick)
                KEEP_CENTRE: tbl[2*i +: 2] = idx[3:2];
                TAKE_LEFT:   tbl[2*i +: 2] = idx[5:4];
                default:     tbl[2*i +: 2] = idx[1:0];
            endcase
        end
        return tbl;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            4:       return $urandom & $urandom & $urandom;
            5:       return $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RULE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_rule_table tbl;
        logic        ring_bit;
        sb = new(CELLS);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item('1, '0, 1'b0);

        program_rules(neighbour_table(KEEP_CENTRE), 64'd1);
        send_item('0, '0, 1'b1);
        send_item(32'hFFFF_0000, '0, 1'b0);
        send_item('0, '1, 1'b0);
        send_item(32'hAAAA_AAAA, '1, 1'b0);
        send_item('0, 32'h5555_5555, 1'b1);
        send_item(32'h5555_5555, '0, 1'b0);
        send_item('1, '1, 1'b1);
        send_item('0, '1, 1'b0);

        program_rules(neighbour_table(TAKE_LEFT), 64'd1);
        send_item(32'h8000_0001, '0, 1'b1);
        send_item('0, '0, 1'b0);
        send_item('0, '0, 1'b0);

        program_rules(neighbour_table(TAKE_LEFT), 64'hFFFF_FFFF_FFFF_FFFE);
        send_item(32'h8000_0001, '0, 1'b1);
        send_item('0, '0, 1'b0);

        program_rules(neighbour_table(TAKE_RIGHT), 64'd0);
        send_item('0, 32'h8000_0001, 1'b1);
        send_item('0, '0, 1'b0);

        program_rules(neighbour_table(TAKE_RIGHT), 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_SPARE, rand_word());
        send_item('0, 32'h8000_0001, 1'b1);
        send_item('0, '0, 1'b0);

        program_rules('1, 64'd1);
        send_item('0, '0, 1'b1);
        program_rules('0, 64'd1);
        send_item('1, '1, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 5)
                0:       tbl = {rand_word(), rand_word()};
                1:       tbl = {rand_word(), {RULE_W{1'b1}}};
                3:       tbl = {{RULE_W{1'b0}}, rand_word()};
                default: tbl = {rand_word(), rand_word()};
            endcase
            ring_bit = 1'($urandom_range(0, 1));
            program_rules(tbl, {63'(rand_word() >> 1), ring_bit});
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_SPARE, rand_word());
            end
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 30) begin
                    no_idle = ($urandom_range(0, 2) == 0);
                    if (ph % 2 == 1) begin
                        drain();
                    end
                end
                send_item(rand_mask(), rand_mask(), (k == 0) || ($urandom_range(0, 24) == 0));
            end
        end

        no_idle = 1'b0;
        drain();
        repeat (8) @(negedge clk);

        $display("Sent %0d input transfers (%0d with restart) and checked %0d rows.",
                 n_items, n_restart, sb.checked);
        $display("Made %0d register writes, %0d of them selecting zero boundaries.",
                 n_cfg, n_ringoff);
        if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Errors: %0d, rows still expected: %0d", sb.errors,
                     sb.expected_rows.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: four_state_ca_row_step_with_morphogen.f
rtl/core/fsca_pkg.sv
rtl/core/fsca_cell.sv
rtl/core/four_state_ca_row_step_with_morphogen.sv
test/tb.sv
